/* design/b64e_pkg.sv */
// shared types, widths and the character table of the base64 bit stream encoder
package b64e_pkg;

  localparam int unsigned SextetW = 6;
  localparam int unsigned CharW   = 7;
  localparam int unsigned HeldW   = 3;
  localparam int unsigned DataW   = 8;
  localparam int unsigned CountW  = 4;

  // command kinds carried in tuser
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // characters produced by one item, oldest first
  typedef struct packed {
    logic [1:0]       num;
    logic [CharW-1:0] ch0;
    logic [CharW-1:0] ch1;
  } char_pair_t;

  // standard alphabet lookup
  function automatic logic [CharW-1:0] sextet_to_char(input logic [SextetW-1:0] s);
    logic [CharW-1:0] c;
    c = 7'd0;
    if (s < 6'd26) begin
      c = 7'h41 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'h61 + {1'b0, s} - 7'd26;
    end else if (s < 6'd62) begin
      c = 7'h30 + {1'b0, s} - 7'd52;
    end else if (s == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

/* design/b64e_pack.sv */
// combinational packer: merges one item into the accumulator and cuts sextets
module b64e_pack import b64e_pkg::*; (
  input  logic               cmd_i,
  input  logic [DataW-1:0]   data_bits_i,
  input  logic [CountW-1:0]  bit_count_i,
  input  logic [SextetW-1:0] acc_i,
  input  logic [HeldW-1:0]   held_i,
  output char_pair_t         pair_o,
  output logic [SextetW-1:0] acc_o,
  output logic [HeldW-1:0]   held_o
);

  logic [CountW-1:0]  cnt_sat;
  logic [DataW-1:0]   masked;
  logic [12:0]        merged;
  logic [CountW-1:0]  total;
  logic [CountW-1:0]  sh_first;
  logic [CountW-1:0]  sh_second;
  logic [12:0]        first_w;
  logic [12:0]        second_w;
  logic [12:0]        rest_w;
  logic [SextetW-1:0] pad;

  // saturate count and line up held bits ahead of the new ones
  assign cnt_sat   = (bit_count_i > 4'd8) ? 4'd8 : bit_count_i;
  assign masked    = data_bits_i & ~(8'hFF << cnt_sat);
  assign merged    = ({7'd0, acc_i} << cnt_sat) | {5'd0, masked};
  assign total     = {1'b0, held_i} + cnt_sat;
  assign sh_first  = total - 4'd6;
  assign sh_second = total - 4'd12;
  assign first_w   = merged >> sh_first;
  assign second_w  = merged >> sh_second;
  assign pad       = acc_i << (3'd6 - held_i);

  // pick result characters and leftover bits
  always_comb begin
    pair_o.num = 2'd0;
    pair_o.ch0 = sextet_to_char(first_w[SextetW-1:0]);
    pair_o.ch1 = sextet_to_char(second_w[SextetW-1:0]);
    rest_w     = merged;
    held_o     = total[HeldW-1:0];
    if (cmd_i == CmdFinish) begin
      pair_o.ch0 = sextet_to_char(pad);
      pair_o.num = (held_i != 3'd0) ? 2'd1 : 2'd0;
      rest_w     = 13'd0;
      held_o     = 3'd0;
    end else if (total >= 4'd12) begin
      pair_o.num = 2'd2;
      rest_w     = merged & ~(13'h1FFF << sh_second);
      held_o     = sh_second[HeldW-1:0];
    end else if (total >= 4'd6) begin
      pair_o.num = 2'd1;
      rest_w     = merged & ~(13'h1FFF << sh_first);
      held_o     = sh_first[HeldW-1:0];
    end
    acc_o = rest_w[SextetW-1:0];
  end

endmodule

/* design/b64e_out.sv */
// result buffer: holds up to two characters and hands them out one per transfer
module b64e_out import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  char_pair_t       pair_i,
  output logic             free_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic             m_axis_tlast_o
);

  logic [1:0]       rem_q, rem_d;
  logic [CharW-1:0] head_q, head_d;
  logic [CharW-1:0] tail_q, tail_d;
  logic             pop;

  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign free_o          = (rem_q == 2'd0) | ((rem_q == 2'd1) & pop);
  assign m_axis_tvalid_o = (rem_q != 2'd0);
  assign m_axis_tdata_o  = {1'b0, head_q};
  assign m_axis_tlast_o  = (rem_q == 2'd1);

  // load a new pair or shift the tail forward
  always_comb begin
    rem_d  = rem_q;
    head_d = head_q;
    tail_d = tail_q;
    if (load_i) begin
      rem_d  = pair_i.num;
      head_d = pair_i.ch0;
      tail_d = pair_i.ch1;
    end else if (pop) begin
      rem_d  = rem_q - 2'd1;
      head_d = tail_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // character payload
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

/* design/base64_bit_stream_encoder.sv */
// top level: input register, accumulator state, packer and result buffer
// path: input register, then packer, then result buffer register, then output
// throughput: one item per cycle while items give at most one character and the
// output is not held back; the one-character-per-cycle output port sets the rate
// reset: asynchronous active low, clears the accumulator, held count and all valid flags
module base64_bit_stream_encoder import b64e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] data_bits, [11:8] bit_count, [15:12] zero
  input  logic        s_axis_tuser_i,   // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast_o
);

  logic               in_vld_q;
  logic               cmd_q;
  logic [DataW-1:0]   data_q;
  logic [CountW-1:0]  cnt_q;
  logic [SextetW-1:0] acc_q, acc_d;
  logic [HeldW-1:0]   held_q, held_d;
  char_pair_t         pair;
  logic               buf_free;
  logic               advance;
  logic               load;

  // item leaves the input register when its characters fit in the buffer
  assign advance         = in_vld_q & ((pair.num == 2'd0) | buf_free);
  assign load            = advance & (pair.num != 2'd0);
  assign s_axis_tready_o = ~in_vld_q | advance;

  b64e_pack u_pack (
    .cmd_i       (cmd_q),
    .data_bits_i (data_q),
    .bit_count_i (cnt_q),
    .acc_i       (acc_q),
    .held_i      (held_q),
    .pair_o      (pair),
    .acc_o       (acc_d),
    .held_o      (held_d)
  );

  b64e_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .pair_i          (pair),
    .free_o          (buf_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // valid flag and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      acc_q    <= '0;
      held_q   <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        acc_q  <= acc_d;
        held_q <= held_d;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q  <= s_axis_tuser_i;
      data_q <= s_axis_tdata_i[7:0];
      cnt_q  <= s_axis_tdata_i[11:8];
    end
  end

endmodule

/* tb/base64_bit_stream_encoder_checker.sv */
// channel monitor, character predictor and scoreboard for the base64 bit stream encoder
`timescale 1ns / 1ps

module base64_bit_stream_encoder_checker import b64e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] data_bits, [11:8] bit_count, [15:12] zero
  input  logic        s_axis_tuser_i,   // [0] cmd
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [6:0] char_code, [7] zero
  input  logic        m_axis_tlast_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  // standard alphabet, index 0 in the top byte
  localparam bit [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last;
  } b64_char_t;

  b64_char_t          char_q[$];
  logic [SextetW-1:0] sextet_acc;
  logic [HeldW-1:0]   held_cnt;
  int unsigned        err_cnt;

  function automatic logic [CharW-1:0] char_of(input logic [SextetW-1:0] s);
    return Alphabet[8*(63-s) +: CharW];
  endfunction

  // append the bits of one item and queue the characters it completes
  task automatic predict_chars(input logic cmd, input logic [DataW-1:0] bits,
                               input logic [CountW-1:0] cnt);
    logic [SextetW-1:0] done [2];
    int                 n_done;
    int                 n_bits;
    n_done = 0;
    if (cmd == CmdFinish) begin
      // flush a partial sextet, zero padded on the right
      if (held_cnt != 0) begin
        done[0] = sextet_acc << (SextetW - held_cnt);
        n_done  = 1;
      end
      sextet_acc = '0;
      held_cnt   = '0;
    end else begin
      // oversized counts saturate at a full byte
      n_bits = (cnt > DataW) ? DataW : cnt;
      for (int i = n_bits - 1; i >= 0; i--) begin
        sextet_acc = {sextet_acc[SextetW-2:0], bits[i]};
        held_cnt++;
        if (held_cnt == SextetW) begin
          done[n_done] = sextet_acc;
          n_done++;
          sextet_acc = '0;
          held_cnt   = '0;
        end
      end
    end
    for (int k = 0; k < n_done; k++) begin
      char_q.push_back(b64_char_t'{char_code: char_of(done[k]), last: (k == n_done - 1)});
    end
  endtask

  // check the output transfer first, so a new item never covers a stray character
  always @(posedge clk_i or negedge rst_ni) begin : watch
    b64_char_t want;
    if (!rst_ni) begin
      char_q.delete();
      sextet_acc = '0;
      held_cnt   = '0;
      err_cnt    = 0;
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (char_q.size() == 0) begin
          $error("char_code: expected none, actual %0h", m_axis_tdata_i[CharW-1:0]);
          err_cnt++;
        end else begin
          want = char_q.pop_front();
          if (m_axis_tdata_i[CharW-1:0] !== want.char_code) begin
            $error("char_code: expected %0h, actual %0h", want.char_code,
                   m_axis_tdata_i[CharW-1:0]);
            err_cnt++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_axis_tlast_i);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_chars(s_axis_tuser_i, s_axis_tdata_i[DataW-1:0],
                      s_axis_tdata_i[DataW +: CountW]);
      end
      pending_o     <= char_q.size();
      error_count_o <= err_cnt;
    end
  end

endmodule

/* tb/base64_bit_stream_encoder_test.sv */
// stimulus, flow control and verdict for the base64 bit stream encoder
`timescale 1ns / 1ps

module base64_bit_stream_encoder_test;
  import b64e_pkg::*;

  localparam int unsigned NumItems  = 1600;
  localparam int unsigned HoldTicks = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = CmdWrite;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  int unsigned error_count;
  int unsigned pending;

  bit steady   = 1'b0;  // no idling on either side while set
  bit hold_req = 1'b0;  // receiver backs off for a long stretch

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  base64_bit_stream_encoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  base64_bit_stream_encoder_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  // one input transfer; called and left at a falling edge
  task automatic send_item(input logic cmd, input logic [DataW-1:0] bits,
                           input logic [CountW-1:0] cnt);
    while (!steady && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, cnt, bits};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender pause until every character is out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: random back pressure plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldTicks) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned     counted;
    int unsigned     kind;
    logic            cmd;
    logic [DataW-1:0]  bits;
    logic [CountW-1:0] cnt;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: finish on empty, full bytes, count extremes, alphabet corners
    send_item(CmdFinish, 8'hFF, 4'd15);
    send_item(CmdWrite,  8'hFF, 4'd8);
    send_item(CmdWrite,  8'h00, 4'd8);
    send_item(CmdWrite,  8'hA5, 4'd0);
    send_item(CmdWrite,  8'h5A, 4'd15);
    send_item(CmdWrite,  8'h03, 4'd9);
    send_item(CmdFinish, 8'h00, 4'd0);
    send_item(CmdWrite,  8'h3E, 4'd6);
    send_item(CmdWrite,  8'h3F, 4'd6);
    send_item(CmdWrite,  8'h34, 4'd6);
    send_item(CmdWrite,  8'h1A, 4'd6);
    send_item(CmdWrite,  8'h19, 4'd6);
    send_item(CmdWrite,  8'h01, 4'd1);
    send_item(CmdFinish, 8'hAA, 4'd3);
    send_item(CmdWrite,  8'h1F, 4'd5);
    send_item(CmdFinish, 8'h55, 4'd8);
    send_item(CmdWrite,  8'h80, 4'd7);
    send_item(CmdWrite,  8'hC3, 4'd2);
    send_item(CmdWrite,  8'h6C, 4'd3);
    send_item(CmdWrite,  8'h0E, 4'd4);
    send_item(CmdFinish, 8'hFF, 4'd15);
    send_item(CmdFinish, 8'h00, 4'd0);
    wait_drained();

    // random: mostly proper writes, some finishes, some odd counts
    counted = 0;
    while (counted < NumItems) begin
      kind = $urandom_range(99);
      bits = 8'($urandom);
      if (kind < 10) begin
        cmd = CmdFinish;
        cnt = 4'($urandom);
      end else if (kind < 16) begin
        cmd = CmdWrite;
        cnt = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
      end else begin
        cmd = CmdWrite;
        cnt = 4'($urandom_range(1, 8));
      end
      send_item(cmd, bits, cnt);
      if (cmd == CmdFinish || cnt != 0) counted++;

      // pressure points and a stretch without idling
      if (counted == 300) hold_req = 1'b1;
      if (counted == 600) wait_drained();
      if (counted == 800) steady = 1'b1;
      if (counted == 1100) steady = 1'b0;
    end

    // drain and settle
    s_tvalid <= 1'b0;
    for (int k = 0; k < 5000 && pending != 0; k++) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (pending != 0) $error("characters never arrived: %0d", pending);
    if (error_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
